FILE: sv/brsdp_pkg.sv
// Package for the bounded range segmentation block.
// Holds sizes, payload structs, register indexes and the controller state type.
// No dependencies.
package brsdp_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W = ADDR_W + 1;
    localparam int COST_W = CNT_W + 1;
    localparam int DATA_W = 32;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_MAX_RANGE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_LENGTH = 2'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic first;
        logic last;
    } in_t;

    typedef struct packed {
        logic [CNT_W-1:0] pieces;
        logic feasible;
        logic final_res;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage

FILE: sv/brsdp_ram.sv
// Generic single write, single read synchronous RAM with registered read data.
// No dependencies.
module brsdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bounded_range_segmentation_dp.sv
// Top level of the bounded range segmentation block: controller and stores.
// Depends on brsdp_pkg and brsdp_ram.
//
// Usage: samples arrive on the in channel (valid/ready), one result leaves on
// the out channel (valid/ready) for every input transaction. Each result gives
// the fewest pieces covering the prefix ending at that sample, with pieces of
// at least min_length samples and a spread of at most max_range.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Scan: an item scans back over the samples of its prefix, starting at its
// own position, until the spread bound fails or the sequence start is reached.
// Each scanned position takes a read state (one read of the sample and cost
// memories) and then an evaluation state, as each memory has a single read
// port. A completion state then loads the result into the output register
// once that register is free; the next input transaction is taken only after
// that, as the input is not ready while an item is worked on.
// Items that arrive after 4096 stored samples skip the scan and go from idle
// straight to the completion state.
// Reset starts an empty sequence with max_range 0 and min_length 1.
// A stalled receiver holds the result in the output register; the next input
// transaction is still taken and is worked on until its own result is ready.
module bounded_range_segmentation_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  brsdp_pkg::in_t                  in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output brsdp_pkg::out_t                 out_data,
    input  logic                            cfg_we,
    input  logic [brsdp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [brsdp_pkg::DATA_W-1:0]    cfg_data
);

    localparam int AW = brsdp_pkg::ADDR_W;
    localparam int CW = brsdp_pkg::CNT_W;
    localparam int KW = brsdp_pkg::COST_W;
    localparam int DW = brsdp_pkg::DATA_W;
    localparam logic [CW-1:0] FULL = CW'(brsdp_pkg::MAX_LEN);

    brsdp_pkg::state_t state_reg, state_next;
    logic [DW-1:0] max_range_reg;
    logic [CW-1:0] min_length_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] len_reg, len_next;
    logic [DW-1:0] maxr_reg, maxr_next;
    logic signed [DW-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [KW-1:0] best_reg, best_next;
    logic found_reg, found_next;
    logic store_reg, store_next;
    logic last_reg, last_next;
    logic out_valid_reg, out_valid_next;
    brsdp_pkg::out_t out_reg, out_next;

    logic smp_we;
    logic [AW-1:0] smp_waddr, smp_raddr;
    logic [DW-1:0] smp_rdata;
    logic cost_we;
    logic [AW-1:0] cost_waddr, cost_raddr;
    logic [KW-1:0] cost_wdata, cost_rdata;

    logic accept;
    logic [CW-1:0] n_base;
    logic signed [DW-1:0] s_val, nh, nl;
    logic [DW:0] spread;
    logic [KW-1:0] cand, best_inc;
    logic cand_ok;

    brsdp_ram #(.WIDTH(DW), .DEPTH(brsdp_pkg::MAX_LEN)) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (in_data.value),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    brsdp_ram #(.WIDTH(KW), .DEPTH(brsdp_pkg::MAX_LEN)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    assign in_ready = (state_reg == brsdp_pkg::ST_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign n_base = in_data.first ? '0 : cnt_reg;
    assign smp_we = accept && (n_base != FULL);
    assign smp_waddr = n_base[AW-1:0];
    assign smp_raddr = AW'(j_reg - CW'(1));
    assign cost_raddr = AW'(j_reg - CW'(2));
    assign cost_waddr = AW'(i_reg - CW'(1));
    assign best_inc = best_reg + KW'(1);
    assign cost_wdata = found_reg ? best_inc : '0;

    assign s_val = $signed(smp_rdata);
    assign nh = (s_val > hi_reg) ? s_val : hi_reg;
    assign nl = (s_val < lo_reg) ? s_val : lo_reg;
    assign spread = {nh[DW-1], nh} - {nl[DW-1], nl};

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        len_next = len_reg;
        maxr_next = maxr_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        best_next = best_reg;
        found_next = found_reg;
        store_next = store_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        cost_we = 1'b0;
        cand = '0;
        cand_ok = 1'b0;
        unique case (state_reg)
            brsdp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    i_next = n_base + CW'(1);
                    j_next = n_base + CW'(1);
                    len_next = (min_length_reg == '0) ? CW'(1) : min_length_reg;
                    maxr_next = max_range_reg;
                    hi_next = in_data.value;
                    lo_next = in_data.value;
                    found_next = 1'b0;
                    best_next = '0;
                    last_next = in_data.last;
                    store_next = (n_base != FULL);
                    if (in_data.first)
                    begin
                        cnt_next = '0;
                    end
                    state_next = (n_base != FULL) ? brsdp_pkg::ST_READ
                                                  : brsdp_pkg::ST_DONE;
                end
            end
            brsdp_pkg::ST_READ:
            begin
                state_next = brsdp_pkg::ST_EVAL;
            end
            brsdp_pkg::ST_EVAL:
            begin
                if (spread > {1'b0, maxr_reg})
                begin
                    state_next = brsdp_pkg::ST_DONE;
                end
                else
                begin
                    hi_next = nh;
                    lo_next = nl;
                    if ({1'b0, i_reg - j_reg} + KW'(1) >= {1'b0, len_reg})
                    begin
                        if (j_reg == CW'(1))
                        begin
                            cand_ok = 1'b1;
                            cand = '0;
                        end
                        else
                        begin
                            cand_ok = (cost_rdata != '0);
                            cand = cost_rdata;
                        end
                        if (cand_ok && (!found_reg || cand < best_reg))
                        begin
                            best_next = cand;
                            found_next = 1'b1;
                        end
                    end
                    if (j_reg == CW'(1))
                    begin
                        state_next = brsdp_pkg::ST_DONE;
                    end
                    else
                    begin
                        j_next = j_reg - CW'(1);
                        state_next = brsdp_pkg::ST_READ;
                    end
                end
            end
            brsdp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.pieces = found_reg ? best_inc[CW-1:0] : '0;
                    out_next.feasible = found_reg;
                    out_next.final_res = last_reg;
                    cost_we = store_reg;
                    if (last_reg)
                    begin
                        cnt_next = '0;
                    end
                    else if (store_reg)
                    begin
                        cnt_next = i_reg;
                    end
                    state_next = brsdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brsdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brsdp_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            max_range_reg <= '0;
            min_length_reg <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == brsdp_pkg::REG_MAX_RANGE)
            begin
                max_range_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == brsdp_pkg::REG_MIN_LENGTH)
            begin
                min_length_reg <= cfg_data[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        len_reg <= len_next;
        maxr_reg <= maxr_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        best_reg <= best_next;
        found_reg <= found_next;
        store_reg <= store_next;
        last_reg <= last_next;
        out_reg <= out_next;
    end

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == brsdp_pkg::ST_EVAL |-> $past(state_reg) == brsdp_pkg::ST_READ)
        else $error("Evaluation without a preceding memory read.");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brsdp_pkg::ST_READ || state_reg == brsdp_pkg::ST_EVAL)
        |-> (j_reg != '0 && j_reg <= i_reg && i_reg <= FULL))
        else $error("Scan position outside the current prefix.");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL)
        else $error("Sample count beyond the store depth.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == brsdp_pkg::ST_DONE)
        else $error("Result loaded outside the completion state.");

endmodule

FILE: bench/bounded_range_segmentation_dp_tb.sv
// Testbench for bounded_range_segmentation_dp: directed and random sample streams
// checked against a built-in predictor of the fewest-pieces prefix cost.
// Depends on brsdp_pkg and the block's RTL.
`timescale 1ns / 1ps

module bounded_range_segmentation_dp_tb;

    localparam int RUN_LIMIT = 3000000;
    localparam int MAX_LEN = brsdp_pkg::MAX_LEN;
    localparam int CNT_W = brsdp_pkg::CNT_W;
    localparam int COST_W = brsdp_pkg::COST_W;
    localparam int LONG_LEN = 1200;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    brsdp_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    brsdp_pkg::out_t out_data;
    logic cfg_we;
    logic [brsdp_pkg::IDX_W-1:0] cfg_index;
    logic [brsdp_pkg::DATA_W-1:0] cfg_data;

    brsdp_pkg::out_t pending_cuts[$];
    int failures = 0;
    int cycle_count = 0;
    bit jitter;
    int hold_asked;
    int hold_taken;
    int hold_left;

    longint seq_samples[0:MAX_LEN];
    logic [COST_W-1:0] seq_cost[0:MAX_LEN];
    bit seq_cost_ok[0:MAX_LEN];
    int seq_count;
    logic [31:0] cur_max_range;
    logic [CNT_W-1:0] cur_min_length;

    bounded_range_segmentation_dp u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void clear_sequence();
        for (int k = 0; k <= MAX_LEN; k++)
            seq_cost_ok[k] = 1'b0;
        seq_cost_ok[0] = 1'b1;
        seq_cost[0] = '0;
        seq_count = 0;
    endfunction

    function automatic brsdp_pkg::out_t cut_prefix(logic signed [31:0] value, bit first,
                                                   bit last);
        brsdp_pkg::out_t res;
        int i;
        int left;
        int right;
        int len;
        longint hi;
        longint lo;
        longint nh;
        longint nl;
        int best;
        bit found;
        res = '0;
        if (first)
            clear_sequence();
        if (seq_count < MAX_LEN)
        begin
            i = seq_count + 1;
            hi = value;
            lo = value;
            left = i;
            len = (cur_min_length == 0) ? 1 : int'(cur_min_length);
            right = i - len;
            best = 0;
            found = 1'b0;
            seq_samples[i] = value;
            for (int j = i - 1; j >= 1; j--)
            begin
                nh = (seq_samples[j] > hi) ? seq_samples[j] : hi;
                nl = (seq_samples[j] < lo) ? seq_samples[j] : lo;
                if (nh - nl > longint'(cur_max_range))
                    break;
                hi = nh;
                lo = nl;
                left = j;
            end
            for (int j = left - 1; j <= right; j++)
            begin
                if (seq_cost_ok[j] && (!found || seq_cost[j] < best))
                begin
                    best = int'(seq_cost[j]);
                    found = 1'b1;
                end
            end
            seq_cost_ok[i] = found;
            seq_cost[i] = found ? COST_W'(best + 1) : '0;
            seq_count = i;
            if (found)
            begin
                res.pieces = CNT_W'(best + 1);
                res.feasible = 1'b1;
            end
        end
        if (last)
            clear_sequence();
        res.final_res = last;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        brsdp_pkg::out_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cuts.size() == 0)
            begin
                $error("unexpected transaction: pieces %0d", out_data.pieces);
                failures++;
            end
            else
            begin
                exp_res = pending_cuts.pop_front();
                if (out_data.pieces !== exp_res.pieces)
                begin
                    $error("pieces: expected %0d, got %0d", exp_res.pieces, out_data.pieces);
                    failures++;
                end
                if (out_data.feasible !== exp_res.feasible)
                begin
                    $error("feasible: expected %0d, got %0d", exp_res.feasible,
                           out_data.feasible);
                    failures++;
                end
                if (out_data.final_res !== exp_res.final_res)
                begin
                    $error("final_res: expected %0d, got %0d", exp_res.final_res,
                           out_data.final_res);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 0;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= jitter ? ($urandom_range(99) >= 32) : 1'b1;
        end
    end

    task automatic send_sample(logic signed [31:0] value, bit first, bit last);
        brsdp_pkg::in_t item;
        item.value = value;
        item.first = first;
        item.last = last;
        if (jitter)
        begin
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_cuts.insert(pending_cuts.size(), cut_prefix(value, first, last));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_cuts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [brsdp_pkg::IDX_W-1:0] index, logic [31:0] data);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == brsdp_pkg::REG_MAX_RANGE)
            cur_max_range = data;
        else if (index == brsdp_pkg::REG_MIN_LENGTH)
            cur_min_length = data[CNT_W-1:0];
        @(posedge clk);
    endtask

    task automatic test_extremes();
        send_sample(32'sd5, 1'b0, 1'b0);
        send_sample(32'sd5, 1'b0, 1'b1);
        send_sample(32'sd7, 1'b0, 1'b1);
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b1);
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'hFFFF_FFFE);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_min_length();
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd10);
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd0);
        send_sample(32'sd1, 1'b1, 1'b0);
        send_sample(32'sd3, 1'b0, 1'b0);
        send_sample(32'sd40, 1'b0, 1'b1);
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd3);
        for (int k = 0; k < 5; k++)
            send_sample(32'(k * 2), k == 0, k == 4);
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd4096);
        send_sample(32'sd0, 1'b1, 1'b0);
        send_sample(32'sd0, 1'b0, 1'b1);
    endtask

    task automatic test_reg_change();
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd1);
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd0);
        send_sample(32'sd4, 1'b1, 1'b0);
        send_sample(32'sd4, 1'b0, 1'b0);
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd100);
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd2);
        send_sample(32'sd50, 1'b0, 1'b0);
        send_sample(32'sd9, 1'b1, 1'b0);
        send_sample(32'sd9, 1'b0, 1'b1);
    endtask

    task automatic test_long_sequence();
        jitter = 1'b0;
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd0);
        write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd1);
        for (int k = 0; k < LONG_LEN; k++)
            send_sample(32'(k % 2), k == 0, k == LONG_LEN - 1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        jitter = 1'b0;
        write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd20);
        hold_asked = hold_asked + 1;
        for (int k = 0; k < 24; k++)
            send_sample(32'($urandom_range(30)), k == 0, k == 23);
        wait_drain();
    endtask

    task automatic test_random();
        int seq_len;
        logic [31:0] base;
        logic [31:0] spread;
        int sent;
        sent = 0;
        while (sent < 620)
        begin
            jitter = (sent < 300) || (sent > 450);
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(4))
                    0: write_reg(brsdp_pkg::REG_MAX_RANGE, 32'd0);
                    1: write_reg(brsdp_pkg::REG_MAX_RANGE, 32'hFFFF_FFFF);
                    2: write_reg(brsdp_pkg::REG_MAX_RANGE, $urandom);
                    default: write_reg(brsdp_pkg::REG_MAX_RANGE, $urandom_range(40));
                endcase
                case ($urandom_range(9))
                    0: write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd0);
                    1: write_reg(brsdp_pkg::REG_MIN_LENGTH, 32'd4096);
                    2: write_reg(brsdp_pkg::REG_MIN_LENGTH, $urandom_range(4096));
                    default: write_reg(brsdp_pkg::REG_MIN_LENGTH, $urandom_range(1, 6));
                endcase
            end
            seq_len = $urandom_range(1, 40);
            base = $urandom;
            spread = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : $urandom_range(60);
            for (int k = 0; k < seq_len; k++)
            begin
                send_sample((spread == 32'hFFFF_FFFF) ? $urandom :
                            base + $urandom_range(spread),
                            (k == 0) ? ($urandom_range(5) != 0) : ($urandom_range(60) == 0),
                            (k == seq_len - 1) ? ($urandom_range(7) != 0) :
                            ($urandom_range(80) == 0));
                sent++;
            end
            if ($urandom_range(15) == 0)
                wait_drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        jitter = 1'b1;
        hold_asked = 0;
        cur_max_range = '0;
        cur_min_length = 1;
        clear_sequence();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_min_length();
        test_reg_change();
        test_backpressure();
        jitter = 1'b1;
        test_random();
        test_long_sequence();
        wait_drain();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
